[rtl/swmf_pkg.sv]
package swmf_pkg;

    localparam int WINDOW_MAX_DEF  = 16;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CFG_BITS        = 5;
    localparam int WIN_RESET       = 5;

    // Links passed rightwards along the sorted chain.
    typedef struct packed {
        logic pre;  // a cell at or left of this one drops out this transaction
        logic le;   // the compacted entry here is valid and not above the new sample
    } t_link;

endpackage

[rtl/swmf_cell.sv]
module swmf_cell #(
    parameter int SAMPLE_BITS = 16,
    parameter int AGE_W       = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  logic                          i_push,
    input  logic                          i_full,
    input  logic [AGE_W-1:0]              i_oldest_age,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_left_valid,
    input  logic [AGE_W-1:0]              i_left_age,
    input  logic signed [SAMPLE_BITS-1:0] i_left_value,
    input  swmf_pkg::t_link               i_left,
    input  logic                          i_right_valid,
    input  logic [AGE_W-1:0]              i_right_age,
    input  logic signed [SAMPLE_BITS-1:0] i_right_value,
    output logic                          o_valid,
    output logic [AGE_W-1:0]              o_age,
    output logic signed [SAMPLE_BITS-1:0] o_value,
    output swmf_pkg::t_link               o_link
);
    import swmf_pkg::*;

    logic                          r_valid;
    logic [AGE_W-1:0]              r_age;
    logic signed [SAMPLE_BITS-1:0] r_value;
    logic                          n_valid;
    logic [AGE_W-1:0]              n_age;
    logic signed [SAMPLE_BITS-1:0] n_value;

    logic                          del;
    logic                          pre;
    logic                          d_valid;
    logic [AGE_W-1:0]              d_age;
    logic signed [SAMPLE_BITS-1:0] d_value;
    logic                          d_le;
    logic                          l_valid;
    logic [AGE_W-1:0]              l_age;
    logic signed [SAMPLE_BITS-1:0] l_value;

    always_comb begin
        // The oldest sample leaves when the window is full.
        del     = r_valid & i_full & (r_age == i_oldest_age);
        pre     = i_left.pre | del;
        // Entry at this place once the leaving sample has been squeezed out.
        d_valid = pre ? i_right_valid : r_valid;
        d_age   = pre ? i_right_age   : r_age;
        d_value = pre ? i_right_value : r_value;
        d_le    = d_valid & (d_value <= i_sample);
        // Compacted entry one place to the left.
        l_valid = i_left.pre ? r_valid : i_left_valid;
        l_age   = i_left.pre ? r_age   : i_left_age;
        l_value = i_left.pre ? r_value : i_left_value;

        n_valid = r_valid;
        n_age   = r_age;
        n_value = r_value;
        if (i_push) begin
            if (d_le) begin
                n_valid = d_valid;
                n_age   = d_age + AGE_W'(1);
                n_value = d_value;
            end else if (i_left.le) begin
                n_valid = 1'b1;
                n_age   = '0;
                n_value = i_sample;
            end else begin
                n_valid = l_valid;
                n_age   = l_age + AGE_W'(1);
                n_value = l_value;
            end
        end

        o_link.pre = pre;
        o_link.le  = d_le;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_age   <= n_age;
        r_value <= n_value;
    end

    assign o_valid = r_valid;
    assign o_age   = r_age;
    assign o_value = r_value;

endmodule

[rtl/sliding_window_median_filter.sv]
// An accepted sample updates the sorted cell chain, and the median is then picked from
// the chain into the output register once that register is free or being read out.
// Throughput: one sample per cycle while the output is not stalled; otherwise the input waits.
// Reset (synchronous, active low) empties the window and sets the window size to five
// (or WINDOW_MAX if smaller); a write of the window size register also empties the window.
module sliding_window_median_filter #(
    parameter int WINDOW_MAX  = swmf_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEF,
    localparam int CNT_W = $clog2(WINDOW_MAX + 1),
    localparam int IN_W  = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((SAMPLE_BITS + CNT_W + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [swmf_pkg::CFG_BITS-1:0] i_cfg_wdata,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [IN_W-1:0]               i_s_tdata,   // sample
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [OUT_W-1:0]              o_m_tdata    // median, fill_count
);
    import swmf_pkg::*;

    localparam int AGE_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int IDX_W   = AGE_W;
    localparam int WIN_RST = (WIN_RESET > WINDOW_MAX) ? WINDOW_MAX : WIN_RESET;

    logic [CNT_W-1:0]              r_win;
    logic [CNT_W-1:0]              r_cnt;
    logic                          r_pend;
    logic                          r_ovalid;
    logic signed [SAMPLE_BITS-1:0] r_median;
    logic [CNT_W-1:0]              r_count;
    logic [CNT_W-1:0]              n_win;

    logic                          accept;
    logic                          out_load;
    logic                          full;
    logic [AGE_W-1:0]              oldest_age;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [CNT_W-1:0]              cnt_m1;
    logic [IDX_W-1:0]              med_idx;

    logic                          c_valid [WINDOW_MAX];
    logic [AGE_W-1:0]              c_age   [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0] c_value [WINDOW_MAX];
    t_link                         c_link  [WINDOW_MAX];

    assign sample     = i_s_tdata[SAMPLE_BITS-1:0];
    assign full       = (r_cnt == r_win);
    assign oldest_age = AGE_W'(r_win - CNT_W'(1));
    assign out_load   = r_pend & (~r_ovalid | i_m_tready);
    assign o_s_tready = ~r_pend | out_load;
    assign accept     = i_s_tvalid & o_s_tready;
    assign cnt_m1     = r_cnt - CNT_W'(1);
    assign med_idx    = IDX_W'(cnt_m1 >> 1);

    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_win = CNT_W'(1);
        end else if (int'(i_cfg_wdata) > WINDOW_MAX) begin
            n_win = CNT_W'(WINDOW_MAX);
        end else begin
            n_win = CNT_W'(i_cfg_wdata);
        end
    end

    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        logic                          left_valid;
        logic [AGE_W-1:0]              left_age;
        logic signed [SAMPLE_BITS-1:0] left_value;
        t_link                         left_link;
        logic                          right_valid;
        logic [AGE_W-1:0]              right_age;
        logic signed [SAMPLE_BITS-1:0] right_value;

        if (g == 0) begin : g_head
            // The new sample always fits ahead of the first cell if nothing precedes it.
            assign left_valid = 1'b0;
            assign left_age   = '0;
            assign left_value = '0;
            assign left_link  = '{pre: 1'b0, le: 1'b1};
        end else begin : g_mid
            assign left_valid = c_valid[g-1];
            assign left_age   = c_age[g-1];
            assign left_value = c_value[g-1];
            assign left_link  = c_link[g-1];
        end

        if (g == WINDOW_MAX - 1) begin : g_tail
            assign right_valid = 1'b0;
            assign right_age   = '0;
            assign right_value = '0;
        end else begin : g_body
            assign right_valid = c_valid[g+1];
            assign right_age   = c_age[g+1];
            assign right_value = c_value[g+1];
        end

        swmf_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .AGE_W       (AGE_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_clear       (i_cfg_we),
            .i_push        (accept),
            .i_full        (full),
            .i_oldest_age  (oldest_age),
            .i_sample      (sample),
            .i_left_valid  (left_valid),
            .i_left_age    (left_age),
            .i_left_value  (left_value),
            .i_left        (left_link),
            .i_right_valid (right_valid),
            .i_right_age   (right_age),
            .i_right_value (right_value),
            .o_valid       (c_valid[g]),
            .o_age         (c_age[g]),
            .o_value       (c_value[g]),
            .o_link        (c_link[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win    <= CNT_W'(WIN_RST);
            r_cnt    <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_win <= n_win;
                r_cnt <= '0;
            end else if (accept && !full) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end

            if (accept) begin
                r_pend <= 1'b1;
            end else if (out_load) begin
                r_pend <= 1'b0;
            end

            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // The chain is sorted, so the lower median sits at a fixed place given the count.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_median <= c_value[med_idx];
            r_count  <= r_cnt;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = OUT_W'({r_count, r_median});

endmodule
